[rtl/icdf_pkg.sv]
package icdf_pkg;

  localparam int MAX_BINS_DEF = 1024;

  localparam int OPC_W  = 2;
  localparam int IDX_W  = 11;
  localparam int CDF_W  = 17;
  localparam int SMP_W  = 16;
  localparam int BIN_W  = 10;
  localparam int FRAC_W = 16;
  localparam int DENS_W = 27;
  localparam int PROD_W = CDF_W + IDX_W;

  localparam logic [OPC_W-1:0] OP_WRITE  = 2'd0;
  localparam logic [OPC_W-1:0] OP_SAMPLE = 2'd1;
  localparam logic [OPC_W-1:0] OP_LOOKUP = 2'd2;

  localparam logic [CDF_W-1:0]  ONE_Q16  = 17'h10000;
  localparam logic [DENS_W-1:0] DENS_MAX = 27'h7FFFFFF;
  localparam logic [FRAC_W-1:0] FRAC_MAX = 16'hFFFF;

  localparam int DIV_STEPS = FRAC_W;
  localparam int CNT_W     = $clog2(DIV_STEPS);

  typedef enum logic [2:0] {
    ST_IDLE,
    ST_TOTAL,
    ST_SEARCH,
    ST_LO,
    ST_HI,
    ST_DIV,
    ST_MUL,
    ST_OUT
  } icdf_state_t;

endpackage

[rtl/inverse_cdf_sampler.sv]
// Piecewise-constant inverse-CDF sampler. Load the table of bins_in_use+1
// cumulative entries (Q1.16) with write words, then issue sample or lookup
// words. A word is taken when start is high and busy is low; its single
// result word appears on the out_ ports for one cycle with out_valid high and
// must be captured then, since the receiver cannot stall the block. A write
// returns its result in the cycle after acceptance and leaves the block ready
// at once. A lookup passes through ST_LO, ST_HI, ST_MUL and ST_OUT. A sample
// reads the total entry, then runs the binary search with one table probe per
// cycle through the single table port, then a 16-step restoring divider for
// the in-bin fraction, then the density multiply. A sample on an empty table
// returns straight from ST_TOTAL, and a zero-width bin, a sample not above the
// bin's lower entry or a saturated fraction skips the divider. busy is high
// while the block is away from ST_IDLE. Table entries read back undefined
// until written.
module inverse_cdf_sampler #(
  parameter int MAX_BINS = icdf_pkg::MAX_BINS_DEF
) (
  input  logic                        clk,
  input  logic                        rst_n,
  input  logic                        cfg_wr_en,
  input  logic [icdf_pkg::IDX_W-1:0]  cfg_wr_data,
  input  logic                        start,
  output logic                        busy,
  input  logic [icdf_pkg::OPC_W-1:0]  in_opcode,
  input  logic [icdf_pkg::IDX_W-1:0]  in_entry_index,
  input  logic [icdf_pkg::CDF_W-1:0]  in_cdf_in,
  input  logic [icdf_pkg::SMP_W-1:0]  in_sample_value,
  output logic                        out_valid,
  output logic [icdf_pkg::BIN_W-1:0]  out_bin_index,
  output logic [icdf_pkg::FRAC_W-1:0] out_fraction,
  output logic [icdf_pkg::CDF_W-1:0]  out_probability,
  output logic [icdf_pkg::DENS_W-1:0] out_density,
  output logic [icdf_pkg::CDF_W-1:0]  out_cdf_out,
  output logic                        out_empty_res,
  output logic                        out_degenerate
);

  localparam int DEPTH = MAX_BINS + 1;
  localparam int AW    = $clog2(DEPTH);
  localparam int BW    = icdf_pkg::IDX_W;
  localparam logic [31:0]   MAX_BINS_U = 32'(MAX_BINS);
  localparam logic [BW-1:0] BINS_CAP   = BW'(MAX_BINS);

  icdf_pkg::icdf_state_t state_r, state_nxt;

  logic [BW-1:0] bins_cfg_r;
  logic [icdf_pkg::OPC_W-1:0] op_r, op_nxt;
  logic [icdf_pkg::SMP_W-1:0] s_r, s_nxt;
  logic [BW-1:0] bins_r, bins_nxt;
  logic [BW-1:0] lo_r, lo_nxt;
  logic [BW-1:0] len_r, len_nxt;
  logic [BW-1:0] mid_r, mid_nxt;
  logic [BW-1:0] i_r, i_nxt;
  logic [icdf_pkg::CDF_W-1:0] base_r, base_nxt;
  logic [icdf_pkg::CDF_W-1:0] p_r, p_nxt;
  logic [icdf_pkg::SMP_W-1:0] rem_r, rem_nxt;
  logic [icdf_pkg::FRAC_W-1:0] q_r, q_nxt;
  logic [icdf_pkg::CNT_W-1:0] cnt_r, cnt_nxt;
  logic [icdf_pkg::PROD_W-1:0] prod_r, prod_nxt;

  logic out_valid_r, out_valid_nxt;
  logic [icdf_pkg::BIN_W-1:0]  res_bin_r, res_bin_nxt;
  logic [icdf_pkg::FRAC_W-1:0] res_frac_r, res_frac_nxt;
  logic [icdf_pkg::CDF_W-1:0]  res_prob_r, res_prob_nxt;
  logic [icdf_pkg::DENS_W-1:0] res_dens_r, res_dens_nxt;
  logic [icdf_pkg::CDF_W-1:0]  res_cdf_r, res_cdf_nxt;
  logic res_empty_r, res_empty_nxt;
  logic res_degen_r, res_degen_nxt;

  logic                       ram_we;
  logic [AW-1:0]              ram_addr;
  logic [icdf_pkg::CDF_W-1:0] ram_wdata;
  logic [icdf_pkg::CDF_W-1:0] ram_rdata;

  logic [BW-1:0] bins_eff;
  logic [BW-1:0] lk_idx;
  logic [icdf_pkg::CDF_W-1:0] wr_val;
  logic          wr_ok;
  logic [BW-1:0] half;
  logic          ge;
  logic [BW-1:0] lo_n, len_n, mid_n, i_sel;
  logic [icdf_pkg::CDF_W-1:0] p_calc;
  logic                       s_gt;
  logic [icdf_pkg::SMP_W-1:0] num;
  logic                       num_ge;
  logic [icdf_pkg::CDF_W-1:0] rem2;
  logic                       sub_ok;

  icdf_ram #(
    .WIDTH(icdf_pkg::CDF_W),
    .DEPTH(DEPTH)
  ) u_table (
    .clk  (clk),
    .we   (ram_we),
    .addr (ram_addr),
    .wdata(ram_wdata),
    .rdata(ram_rdata)
  );

  always_comb begin
    if (bins_cfg_r == '0) begin
      bins_eff = BW'(1);
    end else if (32'(bins_cfg_r) > MAX_BINS_U) begin
      bins_eff = BINS_CAP;
    end else begin
      bins_eff = bins_cfg_r;
    end
  end

  assign lk_idx = (in_entry_index < bins_eff) ? in_entry_index : bins_eff - BW'(1);
  assign wr_val = (in_cdf_in > icdf_pkg::ONE_Q16) ? icdf_pkg::ONE_Q16 : in_cdf_in;
  assign wr_ok  = 32'(in_entry_index) <= MAX_BINS_U;

  // one search probe: upper-bound halving step
  assign half  = len_r >> 1;
  assign ge    = {1'b0, s_r} >= ram_rdata;
  assign lo_n  = ge ? mid_r + BW'(1) : lo_r;
  assign len_n = ge ? len_r - half - BW'(1) : half;
  assign mid_n = lo_n + (len_n >> 1);
  assign i_sel = (lo_n == '0) ? '0 : lo_n - BW'(1);

  assign p_calc = (ram_rdata > base_r) ? ram_rdata - base_r : '0;
  assign s_gt   = {1'b0, s_r} > base_r;
  assign num    = s_r - base_r[icdf_pkg::SMP_W-1:0];
  assign num_ge = {1'b0, num} >= p_calc;

  assign rem2   = {rem_r, 1'b0};
  assign sub_ok = rem2 >= p_r;

  always_comb begin
    state_nxt     = state_r;
    op_nxt        = op_r;
    s_nxt         = s_r;
    bins_nxt      = bins_r;
    lo_nxt        = lo_r;
    len_nxt       = len_r;
    mid_nxt       = mid_r;
    i_nxt         = i_r;
    base_nxt      = base_r;
    p_nxt         = p_r;
    rem_nxt       = rem_r;
    q_nxt         = q_r;
    cnt_nxt       = cnt_r;
    prod_nxt      = prod_r;
    out_valid_nxt = 1'b0;
    res_bin_nxt   = res_bin_r;
    res_frac_nxt  = res_frac_r;
    res_prob_nxt  = res_prob_r;
    res_dens_nxt  = res_dens_r;
    res_cdf_nxt   = res_cdf_r;
    res_empty_nxt = res_empty_r;
    res_degen_nxt = res_degen_r;
    ram_we        = 1'b0;
    ram_addr      = '0;
    ram_wdata     = wr_val;

    case (state_r)
      icdf_pkg::ST_IDLE: begin
        if (start) begin
          op_nxt   = in_opcode;
          s_nxt    = in_sample_value;
          bins_nxt = bins_eff;
          case (in_opcode)
            icdf_pkg::OP_WRITE: begin
              out_valid_nxt = 1'b1;
              res_bin_nxt   = '0;
              res_frac_nxt  = '0;
              res_prob_nxt  = '0;
              res_dens_nxt  = '0;
              res_empty_nxt = 1'b0;
              res_degen_nxt = 1'b0;
              res_cdf_nxt   = '0;
              if (wr_ok) begin
                ram_we      = 1'b1;
                ram_addr    = AW'(in_entry_index);
                res_cdf_nxt = wr_val;
              end
            end
            icdf_pkg::OP_SAMPLE: begin
              ram_addr  = AW'(bins_eff);
              state_nxt = icdf_pkg::ST_TOTAL;
            end
            icdf_pkg::OP_LOOKUP: begin
              ram_addr  = AW'(lk_idx);
              i_nxt     = lk_idx;
              q_nxt     = '0;
              state_nxt = icdf_pkg::ST_LO;
            end
            default: begin
              // unused code: answer with an all-zero word
              out_valid_nxt = 1'b1;
              res_bin_nxt   = '0;
              res_frac_nxt  = '0;
              res_prob_nxt  = '0;
              res_dens_nxt  = '0;
              res_cdf_nxt   = '0;
              res_empty_nxt = 1'b0;
              res_degen_nxt = 1'b0;
            end
          endcase
        end
      end

      icdf_pkg::ST_TOTAL: begin
        if (ram_rdata == '0) begin
          out_valid_nxt = 1'b1;
          res_bin_nxt   = '0;
          res_frac_nxt  = '0;
          res_prob_nxt  = '0;
          res_dens_nxt  = '0;
          res_cdf_nxt   = '0;
          res_empty_nxt = 1'b1;
          res_degen_nxt = 1'b0;
          state_nxt     = icdf_pkg::ST_IDLE;
        end else begin
          lo_nxt    = '0;
          len_nxt   = bins_r;
          mid_nxt   = bins_r >> 1;
          ram_addr  = AW'(bins_r >> 1);
          state_nxt = icdf_pkg::ST_SEARCH;
        end
      end

      icdf_pkg::ST_SEARCH: begin
        lo_nxt  = lo_n;
        len_nxt = len_n;
        if (len_n == '0) begin
          i_nxt     = i_sel;
          ram_addr  = AW'(i_sel);
          state_nxt = icdf_pkg::ST_LO;
        end else begin
          mid_nxt  = mid_n;
          ram_addr = AW'(mid_n);
        end
      end

      icdf_pkg::ST_LO: begin
        base_nxt  = ram_rdata;
        ram_addr  = AW'(i_r + BW'(1));
        state_nxt = icdf_pkg::ST_HI;
      end

      icdf_pkg::ST_HI: begin
        p_nxt     = p_calc;
        state_nxt = icdf_pkg::ST_MUL;
        if (op_r == icdf_pkg::OP_SAMPLE) begin
          q_nxt = '0;
          if (p_calc != '0 && s_gt) begin
            if (num_ge) begin
              q_nxt = icdf_pkg::FRAC_MAX;
            end else begin
              rem_nxt   = num;
              cnt_nxt   = '0;
              state_nxt = icdf_pkg::ST_DIV;
            end
          end
        end
      end

      icdf_pkg::ST_DIV: begin
        // restoring divide, one quotient bit per cycle
        rem_nxt = sub_ok ? icdf_pkg::SMP_W'(rem2 - p_r) : rem2[icdf_pkg::SMP_W-1:0];
        q_nxt   = {q_r[icdf_pkg::FRAC_W-2:0], sub_ok};
        cnt_nxt = cnt_r + icdf_pkg::CNT_W'(1);
        if (cnt_r == icdf_pkg::CNT_W'(icdf_pkg::DIV_STEPS - 1)) begin
          state_nxt = icdf_pkg::ST_MUL;
        end
      end

      icdf_pkg::ST_MUL: begin
        prod_nxt  = icdf_pkg::PROD_W'(p_r) * icdf_pkg::PROD_W'(bins_r);
        state_nxt = icdf_pkg::ST_OUT;
      end

      icdf_pkg::ST_OUT: begin
        out_valid_nxt = 1'b1;
        res_bin_nxt   = i_r[icdf_pkg::BIN_W-1:0];
        res_frac_nxt  = q_r;
        res_prob_nxt  = p_r;
        res_dens_nxt  = prod_r[icdf_pkg::PROD_W-1] ? icdf_pkg::DENS_MAX
                                                   : prod_r[icdf_pkg::DENS_W-1:0];
        res_cdf_nxt   = base_r;
        res_empty_nxt = 1'b0;
        res_degen_nxt = (p_r == '0);
        state_nxt     = icdf_pkg::ST_IDLE;
      end

      default: begin
        state_nxt = icdf_pkg::ST_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= icdf_pkg::ST_IDLE;
      out_valid_r <= 1'b0;
      bins_cfg_r  <= BW'(icdf_pkg::MAX_BINS_DEF);
    end else begin
      state_r     <= state_nxt;
      out_valid_r <= out_valid_nxt;
      if (cfg_wr_en) begin
        bins_cfg_r <= cfg_wr_data;
      end
    end
  end

  always_ff @(posedge clk) begin
    op_r        <= op_nxt;
    s_r         <= s_nxt;
    bins_r      <= bins_nxt;
    lo_r        <= lo_nxt;
    len_r       <= len_nxt;
    mid_r       <= mid_nxt;
    i_r         <= i_nxt;
    base_r      <= base_nxt;
    p_r         <= p_nxt;
    rem_r       <= rem_nxt;
    q_r         <= q_nxt;
    cnt_r       <= cnt_nxt;
    prod_r      <= prod_nxt;
    res_bin_r   <= res_bin_nxt;
    res_frac_r  <= res_frac_nxt;
    res_prob_r  <= res_prob_nxt;
    res_dens_r  <= res_dens_nxt;
    res_cdf_r   <= res_cdf_nxt;
    res_empty_r <= res_empty_nxt;
    res_degen_r <= res_degen_nxt;
  end

  assign busy            = (state_r != icdf_pkg::ST_IDLE);
  assign out_valid       = out_valid_r;
  assign out_bin_index   = res_bin_r;
  assign out_fraction    = res_frac_r;
  assign out_probability = res_prob_r;
  assign out_density     = res_dens_r;
  assign out_cdf_out     = res_cdf_r;
  assign out_empty_res   = res_empty_r;
  assign out_degenerate  = res_degen_r;

  a_done_emits: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r != icdf_pkg::ST_IDLE && state_nxt == icdf_pkg::ST_IDLE) |=> out_valid_r)
    else $error("busy dropped without a result word");

  a_div_rem: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r == icdf_pkg::ST_DIV) |-> ({1'b0, rem_r} < p_r))
    else $error("divider remainder not below bin width");

  a_empty_clean: assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid_r && res_empty_r) |-> (res_prob_r == '0 && res_bin_r == '0 && !res_degen_r))
    else $error("empty result carries bin data");

  a_degen_frac: assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid_r && res_degen_r) |-> (res_frac_r == '0))
    else $error("zero-width bin with nonzero fraction");

endmodule

[rtl/icdf_ram.sv]
module icdf_ram #(
  parameter int WIDTH = 17,
  parameter int DEPTH = 1025
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] addr,
  input  logic [WIDTH-1:0]         wdata,
  output logic [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[addr] <= wdata;
    end
    rdata <= mem[addr];
  end

endmodule
